### rtl/assert_macros.svh
// Assertion shorthands used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is high.
`define SPD_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define SPD_ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/spd_pkg.sv
package spd_pkg;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int HDR_BYTES = 4;

  localparam int IN_DEPTH_DEF  = 2;
  localparam int OUT_DEPTH_DEF = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd2;

  localparam logic [CFG_W-1:0] MIN_LEN_RST = 16'd8;
  localparam logic [CFG_W-1:0] MAX_LEN_RST = 16'd35000;
  localparam logic [CFG_W-1:0] TIMEOUT_RST = 16'd10000;

  localparam logic [7:0] MSG_DISCONNECT = 8'd1;
  localparam logic [7:0] MSG_IGNORE     = 8'd2;
  localparam logic [7:0] MSG_DEBUG      = 8'd4;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_DISCONNECT = 3'd1,
    ST_IGNORE     = 3'd2,
    ST_RANGE      = 3'd3,
    ST_PADDING    = 3'd4,
    ST_TIMEOUT    = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PADLEN  = 2'd1,
    PH_BODY    = 2'd2,
    PH_DISCARD = 2'd3
  } phase_t;

  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        is_status;
    logic [7:0]  payload_byte;
    status_t     status_code;
    logic [31:0] packet_seq;
    logic        last;
  } out_item_t;

  // Classified command handed from the front queue to the engine.
  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } cmd_t;

  // Up to two results per command; r1 is only valid together with r0.
  typedef struct packed {
    logic      v0;
    out_item_t r0;
    logic      v1;
    out_item_t r1;
  } res_pair_t;

endpackage

### rtl/spd_stream_if.sv
interface spd_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/spd_front.sv
// Input queue; classifies each item into a byte or tick command.
// DEPTH must be at least 2.
module spd_front #(
  parameter int DEPTH = spd_pkg::IN_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst,
  spd_stream_if.sink   rx,
  spd_stream_if.source cmd
);
  import spd_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [AW-1:0] wptr, wptr_next;
  logic [AW-1:0] rptr, rptr_next;
  logic [CW-1:0] cnt, cnt_next;
  logic          push, pop;
  cmd_t          cls;

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    if (p == AW'(DEPTH - 1)) begin
      return '0;
    end
    return p + AW'(1);
  endfunction

  assign rx.ready  = (cnt != CW'(DEPTH));
  assign push      = rx.valid && rx.ready;
  assign cmd.valid = (cnt != '0);
  assign cmd.data  = mem[rptr];
  assign pop       = cmd.valid && cmd.ready;

  always_comb begin
    cls.op   = rx.data.opcode ? OP_TICK : OP_BYTE;
    // the byte field means nothing on a tick
    cls.data = rx.data.opcode ? 8'd0 : rx.data.rx_byte;
    wptr_next = push ? bump(wptr) : wptr;
    rptr_next = pop ? bump(rptr) : rptr;
    cnt_next  = cnt + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      wptr <= wptr_next;
      rptr <= rptr_next;
      cnt  <= cnt_next;
    end
  end

endmodule

### rtl/spd_engine.sv
// Packet state machine: one command per cycle while out_room is high, up to two results.
module spd_engine (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [spd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spd_pkg::CFG_W-1:0]      cfg_wdata,
  spd_stream_if.sink                     cmd,
  input  logic                           out_room,
  output spd_pkg::res_pair_t             res
);
  import spd_pkg::*;

  logic [CFG_W-1:0] min_len, max_len, timeout_ticks;

  phase_t      phase, phase_next;
  logic [23:0] hdr, hdr_next;
  logic [15:0] bc, bc_next;
  logic [15:0] len, len_next;
  logic [15:0] pay_end, pay_end_next;
  logic [7:0]  msg_type, msg_type_next;
  logic [15:0] tick_count, tick_count_next;
  logic [31:0] rx_seq, rx_seq_next;

  logic        go;
  logic [7:0]  b;
  logic [31:0] full;
  logic [16:0] total;
  logic        range_err;
  logic [15:0] bc_inc;
  logic [15:0] tick_inc;
  logic        is_payload;
  logic [7:0]  new_mt;
  logic        pay_v, st_v, good, restart;
  status_t     st_code;
  logic [7:0]  good_mt;
  out_item_t   pay_item, st_item;

  function automatic status_t good_status(input logic [7:0] mt);
    if (mt == MSG_DISCONNECT) begin
      return ST_DISCONNECT;
    end
    if (mt == MSG_IGNORE || mt == MSG_DEBUG) begin
      return ST_IGNORE;
    end
    return ST_OK;
  endfunction

  assign go        = cmd.valid && out_room;
  assign cmd.ready = out_room;
  assign b         = cmd.data.data;

  always_comb begin
    full       = {hdr, b};
    total      = {1'b0, full[15:0]} + 17'(HDR_BYTES);
    // any bit from 16 up puts length+4 past every max setting
    range_err  = (full[31:16] != 16'd0) || (total < {1'b0, min_len}) ||
                 (total > {1'b0, max_len});
    bc_inc     = bc + 16'd1;
    tick_inc   = tick_count + 16'd1;
    is_payload = (bc_inc <= pay_end);
    new_mt     = (is_payload && bc_inc == 16'd2) ? b : msg_type;

    phase_next      = phase;
    hdr_next        = hdr;
    bc_next         = bc;
    len_next        = len;
    pay_end_next    = pay_end;
    msg_type_next   = msg_type;
    tick_count_next = tick_count;
    rx_seq_next     = rx_seq;
    pay_v           = 1'b0;
    st_v            = 1'b0;
    st_code         = ST_OK;
    good            = 1'b0;
    good_mt         = msg_type;
    restart         = 1'b0;

    if (go) begin
      case (cmd.data.op)
        OP_TICK: begin
          // ticks before the first header byte are ignored
          if (!(phase == PH_HEADER && bc == 16'd0)) begin
            if (tick_inc >= timeout_ticks) begin
              st_v    = 1'b1;
              st_code = ST_TIMEOUT;
              restart = 1'b1;
            end else begin
              tick_count_next = tick_inc;
            end
          end
        end
        OP_BYTE: begin
          case (phase)
            PH_HEADER: begin
              if (bc == 16'(HDR_BYTES - 1)) begin
                if (range_err) begin
                  st_v    = 1'b1;
                  st_code = ST_RANGE;
                  restart = 1'b1;
                end else if (full[15:0] == 16'd0) begin
                  st_v    = 1'b1;
                  st_code = ST_PADDING;
                  restart = 1'b1;
                end else begin
                  phase_next = PH_PADLEN;
                  len_next   = full[15:0];
                  bc_next    = 16'd0;
                end
              end else begin
                bc_next  = bc_inc;
                hdr_next = {hdr[15:0], b};
              end
            end
            PH_PADLEN: begin
              bc_next = 16'd1;
              if ({8'd0, b} >= len) begin
                if (len == 16'd1) begin
                  st_v    = 1'b1;
                  st_code = ST_PADDING;
                  restart = 1'b1;
                end else begin
                  phase_next = PH_DISCARD;
                end
              end else if (len == 16'd1) begin
                // empty payload
                good = 1'b1;
              end else begin
                phase_next   = PH_BODY;
                pay_end_next = len - {8'd0, b};
              end
            end
            PH_BODY: begin
              bc_next = bc_inc;
              if (is_payload) begin
                pay_v         = 1'b1;
                msg_type_next = new_mt;
              end
              if (bc_inc >= len) begin
                good    = 1'b1;
                good_mt = new_mt;
              end
            end
            PH_DISCARD: begin
              bc_next = bc_inc;
              if (bc_inc >= len) begin
                st_v    = 1'b1;
                st_code = ST_PADDING;
                restart = 1'b1;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end

    if (good) begin
      rx_seq_next = rx_seq + 32'd1;
      st_v        = 1'b1;
      st_code     = good_status(good_mt);
      restart     = 1'b1;
    end

    if (restart) begin
      phase_next      = PH_HEADER;
      bc_next         = 16'd0;
      msg_type_next   = 8'd0;
      tick_count_next = 16'd0;
    end

    pay_item.is_status    = 1'b0;
    pay_item.payload_byte = b;
    pay_item.status_code  = ST_OK;
    pay_item.packet_seq   = rx_seq;
    pay_item.last         = 1'b0;

    st_item.is_status     = 1'b1;
    st_item.payload_byte  = 8'd0;
    st_item.status_code   = st_code;
    st_item.packet_seq    = rx_seq_next;
    st_item.last          = 1'b1;

    res.v0 = pay_v || st_v;
    res.r0 = pay_v ? pay_item : st_item;
    res.v1 = pay_v && st_v;
    res.r1 = st_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_len       <= MIN_LEN_RST;
      max_len       <= MAX_LEN_RST;
      timeout_ticks <= TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_LEN: min_len       <= cfg_wdata;
        CFG_MAX_LEN: max_len       <= cfg_wdata;
        CFG_TIMEOUT: timeout_ticks <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HEADER;
      bc         <= 16'd0;
      msg_type   <= 8'd0;
      tick_count <= 16'd0;
      rx_seq     <= 32'd0;
    end else begin
      phase      <= phase_next;
      bc         <= bc_next;
      msg_type   <= msg_type_next;
      tick_count <= tick_count_next;
      rx_seq     <= rx_seq_next;
    end
  end

  always_ff @(posedge clk) begin
    hdr     <= hdr_next;
    len     <= len_next;
    pay_end <= pay_end_next;
  end

endmodule

### rtl/spd_out_fifo.sv
// Result queue: takes up to two results a cycle, hands out one while res.ready is high.
// DEPTH must be at least 2.
module spd_out_fifo #(
  parameter int DEPTH = spd_pkg::OUT_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  spd_pkg::res_pair_t push,
  output logic               room,
  spd_stream_if.source       res
);
  import spd_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  out_item_t     mem [DEPTH];
  logic [AW-1:0] wptr, wptr1, wptr2, wptr_next;
  logic [AW-1:0] rptr, rptr_next;
  logic [CW-1:0] cnt, cnt_next;
  logic          pop;

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    if (p == AW'(DEPTH - 1)) begin
      return '0;
    end
    return p + AW'(1);
  endfunction

  // room for a full pair of results
  assign room      = (cnt <= CW'(DEPTH - 2));
  assign res.valid = (cnt != '0);
  assign res.data  = mem[rptr];
  assign pop       = res.valid && res.ready;

  always_comb begin
    wptr1     = bump(wptr);
    wptr2     = bump(wptr1);
    wptr_next = push.v1 ? wptr2 : (push.v0 ? wptr1 : wptr);
    rptr_next = pop ? bump(rptr) : rptr;
    cnt_next  = cnt + CW'(push.v0) + CW'(push.v1) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.v0) begin
      mem[wptr] <= push.r0;
    end
    if (push.v1) begin
      mem[wptr1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      wptr <= wptr_next;
      rptr <= rptr_next;
      cnt  <= cnt_next;
    end
  end

endmodule

### rtl/ssh_plain_packet_deframer.sv
// Deframer for unencrypted SSH binary packets.
// rx carries items of in_item_t: a received link byte (opcode 0) or one
// timer tick (opcode 1). res carries out_item_t results: payload bytes,
// then one status item with last set at the end of each packet.
// Registers (min/max packet length, timeout ticks) are written through
// cfg_we/cfg_index/cfg_wdata; the user must write them only while the
// block is idle, which the block itself does not enforce.
// Throughput: one item per cycle while res is not stalled. The engine
// handles one command per cycle and needs room for two results in the
// result queue; a packet's final byte may give two results, which leave
// at one per cycle. An item passes the front queue register, then the
// result queue register, before its result is offered on res.
// Reset (synchronous): queues empty, header phase, counter at zero,
// registers at 8 / 35000 / 10000.
// A stalled receiver fills the result queue, then the engine holds, the
// front queue fills, and rx.ready drops; nothing is lost.
module ssh_plain_packet_deframer #(
  parameter int IN_DEPTH  = spd_pkg::IN_DEPTH_DEF,
  parameter int OUT_DEPTH = spd_pkg::OUT_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [spd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [spd_pkg::CFG_W-1:0]     cfg_wdata,
  spd_stream_if.sink                    rx,
  spd_stream_if.source                  res
);
  import spd_pkg::*;

  spd_stream_if #(.T(cmd_t)) cmd ();

  res_pair_t push;
  logic      out_room;

  spd_front #(.DEPTH(IN_DEPTH)) u_front (
    .clk (clk),
    .rst (rst),
    .rx  (rx),
    .cmd (cmd)
  );

  spd_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .out_room  (out_room),
    .res       (push)
  );

  spd_out_fifo #(.DEPTH(OUT_DEPTH)) u_out (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .room (out_room),
    .res  (res)
  );

endmodule

### rtl/spd_checker.sv
`include "assert_macros.svh"

module spd_checker (
  input logic               clk,
  input logic               rst,
  input logic               res_valid,
  input logic               res_ready,
  input spd_pkg::out_item_t res_data
);
  import spd_pkg::*;

  logic [31:0] seq_seen;
  logic        take;
  logic        good;

  assign take = res_valid && res_ready;
  assign good = (res_data.status_code == ST_OK) ||
                (res_data.status_code == ST_DISCONNECT) ||
                (res_data.status_code == ST_IGNORE);

  // good-packet count as seen on the result port
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_seen <= 32'd0;
    end else if (take && res_data.is_status) begin
      seq_seen <= res_data.packet_seq;
    end
  end

  `SPD_ASSERT_NORST(a_reset_empty, clk, rst |=> !res_valid, "result valid after reset")

  `SPD_ASSERT(a_res_hold, clk, rst, res_valid && !res_ready |=> res_valid && $stable(res_data), "stalled result changed")

  `SPD_ASSERT(a_payload_seq, clk, rst, take && !res_data.is_status |-> res_data.packet_seq == seq_seen, "payload count moved")

  `SPD_ASSERT(a_status_seq, clk, rst, take && res_data.is_status |-> res_data.packet_seq == seq_seen + 32'(good), "status count step wrong")

endmodule

bind ssh_plain_packet_deframer spd_checker u_spd_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_data  (res.data)
);
